[rtl/salc_pkg.sv]
// shared types, codes and helpers for the set-associative lru cache model
`default_nettype none

package salc_pkg;

    // fixed field widths
    localparam int ADDR_W  = 64;
    localparam int TAG_W   = 64;
    localparam int COUNT_W = 32;
    localparam int CFG_W   = 6;
    localparam int CFG_IDX_W = 2;

    // default structural sizes
    localparam int MAX_SET_BITS_DEF = 6;
    localparam int MAX_WAYS_DEF     = 8;
    localparam int STAMP_WIDTH_DEF  = 32;

    // access kinds
    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_STORE  = 2'd1;
    localparam logic [1:0] ACT_MODIFY = 2'd2;
    localparam logic [1:0] ACT_OTHER  = 2'd3;

    // outcome codes
    localparam logic [1:0] OUT_HIT   = 2'd0;
    localparam logic [1:0] OUT_FILL  = 2'd1;
    localparam logic [1:0] OUT_EVICT = 2'd2;
    localparam logic [1:0] OUT_NONE  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS        = 2'd2;

    // configuration reset values
    localparam logic [2:0] RST_SET_BITS    = 3'd4;
    localparam logic [5:0] RST_OFFSET_BITS = 6'd4;
    localparam logic [3:0] RST_WAYS        = 4'd1;

    typedef struct packed {
        logic [1:0]        action;
        logic [ADDR_W-1:0] address;
    } req_t;

    typedef struct packed {
        logic [1:0]         outcome;
        logic               extra_hit;
        logic [COUNT_W-1:0] hit_count;
        logic [COUNT_W-1:0] miss_count;
        logic [COUNT_W-1:0] evict_count;
    } rsp_t;

    // sequencing commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic read;
        logic lookup;
        logic update;
    } cmd_t;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v,
                                                   input logic             en);
        if (en && (v != {COUNT_W{1'b1}}))
            return v + COUNT_W'(1);
        return v;
    endfunction

endpackage

`default_nettype wire

[rtl/salc_ctrl.sv]
// sequencer: accept, row read, compare, row write-back
`default_nettype none

module salc_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    output salc_pkg::cmd_t     cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_READ   = 2'd1;
    localparam logic [1:0] S_LOOK   = 2'd2;
    localparam logic [1:0] S_UPDATE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (start) state_next = S_READ;
            S_READ:   state_next = S_LOOK;
            S_LOOK:   state_next = S_UPDATE;
            S_UPDATE: state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign cmd.capture = (state_reg == S_IDLE) && start;
    assign cmd.read    = (state_reg == S_READ);
    assign cmd.lookup  = (state_reg == S_LOOK);
    assign cmd.update  = (state_reg == S_UPDATE);

endmodule

`default_nettype wire

[rtl/salc_datapath.sv]
// address split, set store, tag compare, lru victim choice and counters
`default_nettype none

module salc_datapath #(
    parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
    parameter int MAX_WAYS     = salc_pkg::MAX_WAYS_DEF,
    parameter int STAMP_WIDTH  = salc_pkg::STAMP_WIDTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire salc_pkg::cmd_t                      cmd,
    input  wire salc_pkg::req_t                      request,
    input  wire logic                                cfg_we,
    input  wire logic [salc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [salc_pkg::CFG_W-1:0]          cfg_data,
    output logic                                     done,
    output salc_pkg::rsp_t                           response
);

    localparam int NUM_SETS = 1 << MAX_SET_BITS;
    localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int TAG_W    = salc_pkg::TAG_W;
    localparam int COUNT_W  = salc_pkg::COUNT_W;

    typedef struct packed {
        logic [MAX_WAYS-1:0]                  valid;
        logic [MAX_WAYS-1:0][TAG_W-1:0]       tag;
        logic [MAX_WAYS-1:0][STAMP_WIDTH-1:0] stamp;
    } row_t;

    // configuration
    logic [2:0] set_bits_reg;
    logic [5:0] offset_bits_reg;
    logic [3:0] ways_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg    <= salc_pkg::RST_SET_BITS;
            offset_bits_reg <= salc_pkg::RST_OFFSET_BITS;
            ways_reg        <= salc_pkg::RST_WAYS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                salc_pkg::CFG_SET_BITS:    set_bits_reg    <= cfg_data[2:0];
                salc_pkg::CFG_OFFSET_BITS: offset_bits_reg <= cfg_data[5:0];
                salc_pkg::CFG_WAYS:        ways_reg        <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // ways in use, zero acting as one
    logic [MAX_WAYS-1:0] way_en;
    always_comb
    begin
        for (int w = 0; w < MAX_WAYS; w++)
            way_en[w] = (w == 0) || (int'(ways_reg) > w);
    end

    // address split
    logic [3:0]              set_shift;
    logic [6:0]              tag_shift;
    logic [TAG_W-1:0]        set_full;
    logic [TAG_W-1:0]        tag_calc;

    always_comb
    begin
        if (int'(set_bits_reg) > MAX_SET_BITS)
            set_shift = 4'(MAX_SET_BITS);
        else
            set_shift = {1'b0, set_bits_reg};
        tag_shift = {1'b0, offset_bits_reg} + {3'b000, set_shift};
        set_full  = (request.address >> offset_bits_reg) & ~({TAG_W{1'b1}} << set_shift);
        tag_calc  = (tag_shift >= 7'd64) ? '0 : (request.address >> tag_shift);
    end

    // per-item registers
    logic [1:0]             action_reg, action_next;
    logic [SET_W-1:0]       set_reg, set_next;
    logic [TAG_W-1:0]       tag_reg, tag_next;
    logic [STAMP_WIDTH-1:0] clock_reg, clock_next;

    always_comb
    begin
        action_next = action_reg;
        set_next    = set_reg;
        tag_next    = tag_reg;
        clock_next  = clock_reg;
        if (cmd.capture)
        begin
            action_next = request.action;
            set_next    = set_full[SET_W-1:0];
            tag_next    = tag_calc;
            clock_next  = clock_reg + STAMP_WIDTH'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clock_reg <= '0;
        else
            clock_reg <= clock_next;
    end

    always_ff @(posedge clk)
    begin
        action_reg <= action_next;
        set_reg    <= set_next;
        tag_reg    <= tag_next;
    end

    // set store, one row per set, live bit per row
    row_t                mem [NUM_SETS];
    row_t                row_reg;
    row_t                row_new;
    logic                live_reg;
    logic [NUM_SETS-1:0] row_live_reg, row_live_next;
    logic                write_en;

    always_ff @(posedge clk)
    begin
        if (cmd.read)
            row_reg <= mem[set_reg];
        if (write_en)
            mem[set_reg] <= row_new;
    end

    always_comb
    begin
        row_live_next = row_live_reg;
        if (write_en)
            row_live_next[set_reg] = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            row_live_reg <= '0;
        else
            row_live_reg <= row_live_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.read)
            live_reg <= row_live_reg[set_reg];
    end

    // compare stage
    logic [MAX_WAYS-1:0]                  line_ok;
    logic [MAX_WAYS-1:0]                  hit_vec_reg;
    logic [MAX_WAYS-1:0]                  empty_vec_reg;
    logic [MAX_WAYS-1:0][STAMP_WIDTH-1:0] age_reg;

    always_comb
    begin
        for (int w = 0; w < MAX_WAYS; w++)
            line_ok[w] = live_reg && row_reg.valid[w] && way_en[w];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            for (int w = 0; w < MAX_WAYS; w++)
            begin
                hit_vec_reg[w]   <= line_ok[w] && (row_reg.tag[w] == tag_reg);
                empty_vec_reg[w] <= way_en[w] && !line_ok[w];
                age_reg[w]       <= clock_reg - row_reg.stamp[w];
            end
        end
    end

    // update stage: way choice
    logic [WAY_W-1:0]       hit_way, empty_way, victim_way, sel_way;
    logic [STAMP_WIDTH-1:0] best_age;
    logic                   any_hit, any_empty, active, is_modify;

    always_comb
    begin
        hit_way   = '0;
        empty_way = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--)
        begin
            if (hit_vec_reg[w])
                hit_way = WAY_W'(w);
            if (empty_vec_reg[w])
                empty_way = WAY_W'(w);
        end
        victim_way = '0;
        best_age   = age_reg[0];
        for (int w = 1; w < MAX_WAYS; w++)
        begin
            if (way_en[w] && (age_reg[w] > best_age))
            begin
                best_age   = age_reg[w];
                victim_way = WAY_W'(w);
            end
        end
        any_hit   = |hit_vec_reg;
        any_empty = |empty_vec_reg;
        if (any_hit)
            sel_way = hit_way;
        else if (any_empty)
            sel_way = empty_way;
        else
            sel_way = victim_way;
        active    = (action_reg != salc_pkg::ACT_OTHER);
        is_modify = (action_reg == salc_pkg::ACT_MODIFY);
        write_en  = cmd.update && active;

        row_new       = row_reg;
        row_new.valid = live_reg ? row_reg.valid : '0;
        row_new.valid[sel_way] = 1'b1;
        row_new.tag[sel_way]   = tag_reg;
        row_new.stamp[sel_way] = clock_reg;
    end

    // running totals and result
    logic [COUNT_W-1:0] hits_reg, hits_next;
    logic [COUNT_W-1:0] misses_reg, misses_next;
    logic [COUNT_W-1:0] evicts_reg, evicts_next;
    logic               done_reg, done_next;
    salc_pkg::rsp_t     rsp_reg, rsp_next;

    always_comb
    begin
        hits_next   = hits_reg;
        misses_next = misses_reg;
        evicts_next = evicts_reg;
        rsp_next    = rsp_reg;
        done_next   = cmd.update;
        if (write_en)
        begin
            hits_next   = salc_pkg::sat_inc(salc_pkg::sat_inc(hits_reg, any_hit), is_modify);
            misses_next = salc_pkg::sat_inc(misses_reg, !any_hit);
            evicts_next = salc_pkg::sat_inc(evicts_reg, !any_hit && !any_empty);
        end
        if (cmd.update)
        begin
            if (!active)
                rsp_next.outcome = salc_pkg::OUT_NONE;
            else if (any_hit)
                rsp_next.outcome = salc_pkg::OUT_HIT;
            else if (any_empty)
                rsp_next.outcome = salc_pkg::OUT_FILL;
            else
                rsp_next.outcome = salc_pkg::OUT_EVICT;
            rsp_next.extra_hit   = active && is_modify;
            rsp_next.hit_count   = hits_next;
            rsp_next.miss_count  = misses_next;
            rsp_next.evict_count = evicts_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hits_reg   <= '0;
            misses_reg <= '0;
            evicts_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            hits_reg   <= hits_next;
            misses_reg <= misses_next;
            evicts_reg <= evicts_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign done     = done_reg;
    assign response = rsp_reg;

endmodule

`default_nettype wire

[rtl/set_assoc_lru_cache_model_top.sv]
// top level of the set-associative lru cache hit/miss/evict model
//
// usage
//  - request item (action, address) is taken at a rising edge with start high
//    and busy low; busy stays high until that item's work is done
//  - each item gives one result item on response, marked by done for exactly
//    one cycle; the receiver cannot hold it off, so it must take it then
//  - configuration (set index bits, block offset bits, ways in use) is written
//    through cfg_we / cfg_index / cfg_data while no item is in flight
//  - done rises from a register after the read, compare and update states;
//    busy drops as done rises, so a new item can be taken while done is shown
//  - one item at a time, paced by the read-modify-write of one set row
//    through the single store port: accept, row read, tag compare and
//    age calculation, then victim choice with row write-back and counters
//  - the store keeps one row per set; a live bit per row marks rows ever
//    written, so reset invalidates every line at once with no clearing pass
//  - reset clears the sequencer, live bits, access clock and totals, and loads
//    the default configuration; result payload holds no reset value
`default_nettype none

module set_assoc_lru_cache_model_top #(
    parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
    parameter int MAX_WAYS     = salc_pkg::MAX_WAYS_DEF,
    parameter int STAMP_WIDTH  = salc_pkg::STAMP_WIDTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire salc_pkg::req_t                 request,
    output logic                                done,
    output salc_pkg::rsp_t                      response,
    input  wire logic                           cfg_we,
    input  wire logic [salc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [salc_pkg::CFG_W-1:0]     cfg_data
);

    // command bundle from sequencer to datapath
    salc_pkg::cmd_t cmd;

    salc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    salc_datapath #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS),
        .STAMP_WIDTH  (STAMP_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .request   (request),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .response  (response)
    );

endmodule

`default_nettype wire

[rtl/salc_checker.sv]
// port-level checks for the cache model top level, with bind
`default_nettype none

module salc_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           start,
    input wire logic           busy,
    input wire logic           done,
    input wire salc_pkg::rsp_t response
);

    // accepted item keeps the block busy and shows no stale result next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted item did not raise busy");

    // result only after work and never while still busy
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy)))
        else $error("result strobe outside end of item");

    // a result is one cycle wide
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // extra hit only on a real access, and evictions never exceed misses
    a_result_sane: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((response.outcome != salc_pkg::OUT_NONE || !response.extra_hit)
                  && (response.miss_count >= response.evict_count)))
        else $error("inconsistent result item");

endmodule

bind set_assoc_lru_cache_model_top salc_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .done     (done),
    .response (response)
);

`default_nettype wire

[tb/tb_set_assoc_lru_cache_model_top.sv]
`timescale 1ns / 100ps
// self-checking testbench for the set-associative lru cache model top level
module tb_set_assoc_lru_cache_model_top;

    // widths taken from the package
    localparam int TAG_W     = salc_pkg::TAG_W;
    localparam int COUNT_W   = salc_pkg::COUNT_W;
    localparam int CFG_W     = salc_pkg::CFG_W;
    localparam int CFG_IDX_W = salc_pkg::CFG_IDX_W;

    // store geometry as the block is built by default
    localparam int NUM_SETS  = 1 << salc_pkg::MAX_SET_BITS_DEF;
    localparam int NUM_LINES = NUM_SETS * salc_pkg::MAX_WAYS_DEF;
    localparam int STAMP_W   = salc_pkg::STAMP_WIDTH_DEF;

    // index with no register behind it, written in the directed table and in some random phases to show it is ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // shape of the random part
    localparam int RANDOM_PHASES   = 12;
    localparam int ITEMS_PER_PHASE = 100;

    // one row of the directed table: a register write or an access item,
    // optionally with its result written out by hand
    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_W-1:0]     reg_val;
        salc_pkg::req_t       req;
        bit                   pinned;
        salc_pkg::rsp_t       want;
    } plan_row_t;

    // hand-written result travelling alongside each item sent
    typedef struct {
        bit             pinned;
        salc_pkg::rsp_t value;
    } typed_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 start     = 1'b0;
    salc_pkg::req_t       request   = '0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 busy;
    logic                 done;
    salc_pkg::rsp_t       response;

    set_assoc_lru_cache_model_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .response  (response),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // cache predictor: its own copy of the lines, clock, totals and the
    // configuration registers, advanced once per accepted item
    // ------------------------------------------------------------------
    bit                 line_live    [NUM_LINES];
    bit [TAG_W-1:0]     line_tag_m   [NUM_LINES];
    bit [STAMP_W-1:0]   line_stamp_m [NUM_LINES];
    bit [STAMP_W-1:0]   access_tick;
    bit [COUNT_W-1:0]   hits_seen;
    bit [COUNT_W-1:0]   misses_seen;
    bit [COUNT_W-1:0]   evicts_seen;
    bit [2:0]           cfg_set_bits = salc_pkg::RST_SET_BITS;
    bit [5:0]           cfg_off_bits = salc_pkg::RST_OFFSET_BITS;
    bit [3:0]           cfg_ways     = salc_pkg::RST_WAYS;

    salc_pkg::rsp_t     pending_rsp [$];   // results owed by the block, oldest first
    typed_t             typed_q [$];       // per item sent, in order of sending
    plan_row_t          plan [$];          // directed table
    logic [63:0]        tag_pool [16];     // tags reused within a random phase
    int                 mismatch_count = 0;

    function automatic bit [COUNT_W-1:0] bump_sat(input bit [COUNT_W-1:0] v);
        return (&v) ? v : v + COUNT_W'(1);
    endfunction

    function automatic salc_pkg::rsp_t predict_access(input salc_pkg::req_t r);
        int               s;
        int               b;
        int               ways;
        int               base;
        int               victim;
        bit [63:0]        set_no;
        bit [TAG_W-1:0]   tag;
        bit [STAMP_W-1:0] age;
        bit [STAMP_W-1:0] oldest;
        bit               placed;
        salc_pkg::rsp_t   res;
        // every item, ignored ones too, moves the clock on
        access_tick = access_tick + STAMP_W'(1);
        res         = '0;
        res.outcome = salc_pkg::OUT_NONE;
        if (r.action != salc_pkg::ACT_OTHER)
        begin
            // oversized set bits clamp, ways of 0 act as 1, above the maximum clamp
            s    = (cfg_set_bits > salc_pkg::MAX_SET_BITS_DEF) ? salc_pkg::MAX_SET_BITS_DEF
                                                               : int'(cfg_set_bits);
            b    = int'(cfg_off_bits);
            ways = (cfg_ways == 0) ? 1 :
                   ((cfg_ways > salc_pkg::MAX_WAYS_DEF) ? salc_pkg::MAX_WAYS_DEF
                                                        : int'(cfg_ways));
            set_no = (r.address >> b) & ((64'd1 << s) - 64'd1);
            // tag is whatever lies above the set bits, nothing once past bit 63
            tag    = (b + s >= 64) ? '0 : TAG_W'(r.address >> (b + s));
            base   = int'(set_no) * salc_pkg::MAX_WAYS_DEF;
            placed = 1'b0;
            for (int w = 0; w < ways && !placed; w++)
            begin
                if (line_live[base + w] && line_tag_m[base + w] == tag)
                begin
                    line_stamp_m[base + w] = access_tick;
                    hits_seen   = bump_sat(hits_seen);
                    res.outcome = salc_pkg::OUT_HIT;
                    placed      = 1'b1;
                end
            end
            // first empty way in use takes the line
            for (int w = 0; w < ways && !placed; w++)
            begin
                if (!line_live[base + w])
                begin
                    line_live[base + w]    = 1'b1;
                    line_tag_m[base + w]   = tag;
                    line_stamp_m[base + w] = access_tick;
                    misses_seen = bump_sat(misses_seen);
                    res.outcome = salc_pkg::OUT_FILL;
                    placed      = 1'b1;
                end
            end
            // all ways full: oldest by wrapped age goes, lowest way on a tie
            if (!placed)
            begin
                victim = 0;
                oldest = '0;
                for (int w = 0; w < ways; w++)
                begin
                    age = access_tick - line_stamp_m[base + w];
                    if (w == 0 || age > oldest)
                    begin
                        oldest = age;
                        victim = w;
                    end
                end
                line_live[base + victim]    = 1'b1;
                line_tag_m[base + victim]   = tag;
                line_stamp_m[base + victim] = access_tick;
                misses_seen = bump_sat(misses_seen);
                evicts_seen = bump_sat(evicts_seen);
                res.outcome = salc_pkg::OUT_EVICT;
            end
            // a modify also counts its store as a hit
            if (r.action == salc_pkg::ACT_MODIFY)
            begin
                hits_seen     = bump_sat(hits_seen);
                res.extra_hit = 1'b1;
            end
        end
        res.hit_count   = hits_seen;
        res.miss_count  = misses_seen;
        res.evict_count = evicts_seen;
        return res;
    endfunction

    task automatic note_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // monitor: everything sampled at the rising edge, so values are the
    // ones that held during the cycle that edge ends
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : watch_results
        salc_pkg::rsp_t want;
        salc_pkg::rsp_t model_rsp;
        typed_t         pin;
        if (rst_n)
        begin
            // register copies follow the write port
            if (cfg_we)
            begin
                case (cfg_index)
                    salc_pkg::CFG_SET_BITS:    cfg_set_bits = cfg_data[2:0];
                    salc_pkg::CFG_OFFSET_BITS: cfg_off_bits = cfg_data;
                    salc_pkg::CFG_WAYS:        cfg_ways     = cfg_data[3:0];
                    default:                   ;
                endcase
            end
            // result strobe: compare against the oldest owed result
            if (done)
            begin
                if (pending_rsp.size() == 0)
                begin
                    note_mismatch("result with none expected", 64'(response.outcome), '0);
                end
                else
                begin
                    want = pending_rsp.pop_front();
                    if (response.outcome !== want.outcome)
                        note_mismatch("outcome", 64'(response.outcome), 64'(want.outcome));
                    if (response.extra_hit !== want.extra_hit)
                        note_mismatch("extra_hit", 64'(response.extra_hit),
                                      64'(want.extra_hit));
                    if (response.hit_count !== want.hit_count)
                        note_mismatch("hit_count", 64'(response.hit_count),
                                      64'(want.hit_count));
                    if (response.miss_count !== want.miss_count)
                        note_mismatch("miss_count", 64'(response.miss_count),
                                      64'(want.miss_count));
                    if (response.evict_count !== want.evict_count)
                        note_mismatch("evict_count", 64'(response.evict_count),
                                      64'(want.evict_count));
                end
            end
            // item taken: predictor always runs so its state stays in step,
            // a hand-written result replaces its answer where one was given
            if (start && !busy)
            begin
                model_rsp = predict_access(request);
                if (typed_q.size() != 0)
                begin
                    pin = typed_q.pop_front();
                    pending_rsp.push_back(pin.pinned ? pin.value : model_rsp);
                end
                else
                begin
                    pending_rsp.push_back(model_rsp);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // driving helpers, all called at a rising edge
    // ------------------------------------------------------------------
    function automatic void plan_cfg(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_W-1:0] val);
        plan_row_t row;
        row.is_cfg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        row.req     = '0;
        row.pinned  = 1'b0;
        row.want    = '0;
        plan.push_back(row);
    endfunction

    function automatic void plan_pinned(input logic [1:0] act, input logic [63:0] addr,
                                        input bit pinned, input logic [1:0] outcome,
                                        input logic extra, input logic [COUNT_W-1:0] hits,
                                        input logic [COUNT_W-1:0] misses,
                                        input logic [COUNT_W-1:0] evicts);
        plan_row_t row;
        row.is_cfg           = 1'b0;
        row.reg_idx          = '0;
        row.reg_val          = '0;
        row.req.action       = act;
        row.req.address      = addr;
        row.pinned           = pinned;
        row.want.outcome     = outcome;
        row.want.extra_hit   = extra;
        row.want.hit_count   = hits;
        row.want.miss_count  = misses;
        row.want.evict_count = evicts;
        plan.push_back(row);
    endfunction

    function automatic void plan_access(input logic [1:0] act, input logic [63:0] addr);
        plan_pinned(act, addr, 1'b0, salc_pkg::OUT_NONE, 1'b0, '0, '0, '0);
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // start stays high until the item is taken; not lowered here so that a
    // following item can go straight out
    task automatic send_item(input salc_pkg::req_t r, input bit pinned,
                             input salc_pkg::rsp_t want);
        typed_t t;
        t.pinned = pinned;
        t.value  = want;
        typed_q.push_back(t);
        start   <= 1'b1;
        request <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic rest(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // hold off until the block owes nothing; every item gives a result, so
    // the block is idle once the queue is empty
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (pending_rsp.size() != 0)
            @(posedge clk);
    endtask

    // each write is followed by an idle wait with cfg_we low, which keeps cfg_we
    // from being lowered and raised in the same step
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin : run_test
        salc_pkg::req_t r;
        salc_pkg::rsp_t blank;
        int   gap;
        int   sel;
        int   pool_n;
        int   eff_s;
        int   ob;
        int   sb_val;
        int   ob_val;
        int   wy_val;
        bit   steady;
        blank = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset configuration: 4 set bits, 4 offset bits, one way
        plan_pinned(salc_pkg::ACT_LOAD,   64'h0,
                    1'b1, salc_pkg::OUT_FILL,  1'b0, 0, 1, 0);
        plan_pinned(salc_pkg::ACT_LOAD,   64'h0,
                    1'b1, salc_pkg::OUT_HIT,   1'b0, 1, 1, 0);
        plan_pinned(salc_pkg::ACT_STORE,  64'hFFFF_FFFF_FFFF_FFFF,
                    1'b1, salc_pkg::OUT_FILL,  1'b0, 1, 2, 0);
        plan_pinned(salc_pkg::ACT_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF,
                    1'b1, salc_pkg::OUT_HIT,   1'b1, 3, 2, 0);
        // ignored access leaves the totals alone
        plan_pinned(salc_pkg::ACT_OTHER,  64'h1234,
                    1'b1, salc_pkg::OUT_NONE,  1'b0, 3, 2, 0);
        // same set, new tag, single way: eviction
        plan_pinned(salc_pkg::ACT_LOAD,   64'h100,
                    1'b1, salc_pkg::OUT_EVICT, 1'b0, 3, 3, 1);
        plan_pinned(salc_pkg::ACT_MODIFY, 64'h200,
                    1'b1, salc_pkg::OUT_EVICT, 1'b1, 4, 4, 2);
        // ways above the maximum clamp to eight; the evicted lines' ways refill
        plan_cfg(salc_pkg::CFG_WAYS, 6'd15);
        plan_access(salc_pkg::ACT_LOAD,  64'h300);
        plan_access(salc_pkg::ACT_LOAD,  64'h0);
        plan_access(salc_pkg::ACT_LOAD,  64'h100);
        plan_access(salc_pkg::ACT_STORE, 64'h200);
        // fewer ways: lines beyond them are no longer looked at
        plan_cfg(salc_pkg::CFG_WAYS, 6'd2);
        plan_access(salc_pkg::ACT_LOAD, 64'h400);
        plan_access(salc_pkg::ACT_LOAD, 64'h300);
        // set bits too large clamp, and the tag shift runs past the address
        plan_cfg(salc_pkg::CFG_SET_BITS,    6'h3F);
        plan_cfg(salc_pkg::CFG_OFFSET_BITS, 6'd60);
        plan_access(salc_pkg::ACT_LOAD,  64'hF000_0000_0000_0000);
        plan_access(salc_pkg::ACT_STORE, 64'hF0FF_FFFF_FFFF_FFFF);
        plan_cfg(salc_pkg::CFG_OFFSET_BITS, 6'd63);
        plan_access(salc_pkg::ACT_LOAD, 64'h8000_0000_0000_0000);
        plan_access(salc_pkg::ACT_LOAD, 64'h7FFF_FFFF_FFFF_FFFF);
        // no set bits, no offset, ways of zero act as one, full-width tags
        plan_cfg(salc_pkg::CFG_SET_BITS,    6'd0);
        plan_cfg(salc_pkg::CFG_OFFSET_BITS, 6'd0);
        plan_cfg(salc_pkg::CFG_WAYS,        6'd0);
        plan_cfg(CFG_SPARE,                 6'h3F);
        plan_access(salc_pkg::ACT_LOAD,   64'hFFFF_FFFF_FFFF_FFFF);
        plan_access(salc_pkg::ACT_LOAD,   64'h7FFF_FFFF_FFFF_FFFF);
        plan_access(salc_pkg::ACT_MODIFY, 64'h8000_0000_0000_0000);
        plan_access(salc_pkg::ACT_OTHER,  64'h0);
        plan_access(salc_pkg::ACT_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                wait_drained();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end
            else
            begin
                gap = pick_gap();
                if (gap > 0)
                    rest(gap);
                send_item(plan[i].req, plan[i].pinned, plan[i].want);
            end
        end

        // random phases, each under its own configuration; the first three
        // pin the extremes, the rest draw every register field at random
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            wait_drained();
            case (ph)
                0:
                begin
                    sb_val = 6;
                    ob_val = 4;
                    wy_val = 8;
                end
                1:
                begin
                    sb_val = 0;
                    ob_val = 0;
                    wy_val = 1;
                end
                2:
                begin
                    sb_val = 7;
                    ob_val = 63;
                    wy_val = 0;
                end
                default:
                begin
                    sb_val = $urandom_range(0, 63);
                    case ($urandom_range(0, 5))
                        0:       ob_val = 0;
                        1:       ob_val = 63;
                        2:       ob_val = $urandom_range(0, 63);
                        default: ob_val = $urandom_range(0, 10);
                    endcase
                    wy_val = $urandom_range(0, 63);
                end
            endcase
            write_reg(salc_pkg::CFG_SET_BITS,    CFG_W'(sb_val));
            write_reg(salc_pkg::CFG_OFFSET_BITS, CFG_W'(ob_val));
            write_reg(salc_pkg::CFG_WAYS,        CFG_W'(wy_val));
            if (ph % 4 == 3)
                write_reg(CFG_SPARE, CFG_W'($urandom_range(0, 63)));

            // a small set of tags over a handful of sets, so lines get hit,
            // fill up and get thrown out again
            pool_n = $urandom_range(2, 16);
            for (int k = 0; k < 16; k++)
                tag_pool[k] = $urandom_range(0, 1) ? {$urandom, $urandom}
                                                   : 64'($urandom_range(0, 7));
            steady = ($urandom_range(0, 3) == 0);

            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                if (!steady)
                begin
                    if ($urandom_range(0, 49) == 0)
                    begin
                        wait_drained();
                    end
                    else
                    begin
                        gap = pick_gap();
                        if (gap > 0)
                            rest(gap);
                    end
                end
                sel = $urandom_range(0, 15);
                r.action = (sel < 6)  ? salc_pkg::ACT_LOAD :
                           (sel < 11) ? salc_pkg::ACT_STORE :
                           (sel < 14) ? salc_pkg::ACT_MODIFY : salc_pkg::ACT_OTHER;
                if ($urandom_range(0, 4) == 0)
                begin
                    // fully random address, reaches every bit and every set
                    r.address = {$urandom, $urandom};
                end
                else
                begin
                    eff_s = (cfg_set_bits > salc_pkg::MAX_SET_BITS_DEF)
                          ? salc_pkg::MAX_SET_BITS_DEF : int'(cfg_set_bits);
                    ob    = int'(cfg_off_bits);
                    r.address = ({$urandom, $urandom} & ((64'd1 << ob) - 64'd1))
                              | ((64'($urandom_range(0, 3)) & ((64'd1 << eff_s) - 64'd1))
                                 << ob);
                    if (ob + eff_s < 64)
                        r.address |= tag_pool[$urandom_range(0, pool_n - 1)] << (ob + eff_s);
                end
                send_item(r, 1'b0, blank);
            end
        end

        // let the last results in, then wait quietly for strays
        wait_drained();
        repeat (12) @(posedge clk);
        if (pending_rsp.size() != 0)
            note_mismatch("results never delivered", 64'(pending_rsp.size()), '0);
        if (mismatch_count == 0)
            $display("tb_set_assoc_lru_cache_model_top: clean");
        else
            $display("tb_set_assoc_lru_cache_model_top: errors");
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial
    begin : hang_guard
        #5_000_000;
        $display("tb_set_assoc_lru_cache_model_top: errors");
        $finish;
    end

endmodule
